@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is high
`define CPF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also runs during reset
`define CPF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/cpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types, codes and the crc-16/ccitt-false byte update for the framer.
// ----------------------------------------------------------------------------
package cpf_pkg;

  // request kinds
  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_LOWER  = 2'd1;
  localparam logic [1:0] KIND_RAISE  = 2'd2;
  localparam logic [1:0] KIND_PANIC  = 2'd3;

  // frame constants
  localparam logic [7:0]  HDR_BASE    = 8'hD0;
  localparam logic [7:0]  RAISE_VALUE = 8'd64;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  // byte positions inside a frame
  localparam int         IDX_W      = 3;
  localparam logic [2:0] IDX_HEADER = 3'd0;
  localparam logic [2:0] IDX_DTYPE  = 3'd1;
  localparam logic [2:0] IDX_AXIS0  = 3'd2;
  localparam logic [2:0] IDX_AXIS1  = 3'd3;
  localparam logic [2:0] IDX_AXIS2  = 3'd4;
  localparam logic [2:0] IDX_AXIS3  = 3'd5;
  localparam logic [2:0] IDX_CRC_LO = 3'd6;
  localparam logic [2:0] IDX_CRC_HI = 3'd7;

  // one classified frame waiting for the back end
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] dtype;
    logic [7:0] axis0;
    logic [7:0] axis1;
    logic [7:0] axis2;
    logic [7:0] axis3;
  } frame_desc_t;

  // queue push side
  typedef struct packed {
    logic        push;
    frame_desc_t desc;
  } front_out_t;

  // queue pop side
  typedef struct packed {
    logic        valid;
    frame_desc_t desc;
  } queue_out_t;

  // crc-16/ccitt-false, poly 0x1021, one byte folded in
  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = {crc_in[7:0], crc_in[15:8]};
    c = c ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

@@ rtl/core/control_packet_framer_crc16.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_packet_framer_crc16
// Builds 8-byte control frames with a crc-16/ccitt-false trailer.
// ----------------------------------------------------------------------------
// usage:
//   s_* takes one request word: the kind on s_tuser, the mode, axes and
//   tuning code on s_tdata. m_* sends the frame one byte per word, header,
//   data type, four axis bytes, then crc low and crc high; m_tlast marks
//   the eighth byte.
//   with the queue empty and the sender idle, a taken request is first
//   written into the queue, then loaded into the sender, which then shows
//   the header byte as valid; the crc bytes follow the axis bytes with no gap.
//   one frame is eight output words, sent by the output channel at one
//   byte per cycle while m_tready is high. frames run back to back when
//   the queue already holds the next one.
//   a queue of FIFO_DEPTH frames sits between the request side and the
//   byte sender, so s_tready stays high while the sender is busy until
//   the queue is full.
//   a stall on m_tready holds the current byte; requests keep entering
//   until the queue fills, then s_tready drops.
//   reset clears the queue, the sender and the kept data type (to zero).
// ----------------------------------------------------------------------------
module control_packet_framer_crc16 #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // flight_mode[3:0], roll[11:4], pitch[19:12], yaw[27:20], lift[35:28],
  // tuning_code[42:36], zero fill[47:43]
  input  logic [47:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // frame_byte[7:0]
  output logic [7:0]  m_tdata,
  output logic        m_tlast
);
  import cpf_pkg::*;

  front_out_t front_out;
  queue_out_t queue_out;
  logic       queue_full;
  logic       pop;

  // request classification
  cpf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .kind        (s_tuser),
    .flight_mode (s_tdata[3:0]),
    .roll        (s_tdata[11:4]),
    .pitch       (s_tdata[19:12]),
    .yaw         (s_tdata[27:20]),
    .lift        (s_tdata[35:28]),
    .tuning_code (s_tdata[42:36]),
    .queue_full  (queue_full),
    .in_ready    (s_tready),
    .front_out   (front_out)
  );

  // frame queue
  cpf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .front_out (front_out),
    .pop       (pop),
    .full      (queue_full),
    .queue_out (queue_out)
  );

  // byte sender
  cpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .queue_out  (queue_out),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .frame_byte (m_tdata),
    .last       (m_tlast)
  );

endmodule

@@ rtl/core/cpf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_front
// Accepts requests, classifies them by kind and builds the frame fields.
// ----------------------------------------------------------------------------
module cpf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          kind,
  input  logic [3:0]          flight_mode,
  input  logic [7:0]          roll,
  input  logic [7:0]          pitch,
  input  logic [7:0]          yaw,
  input  logic [7:0]          lift,
  input  logic [6:0]          tuning_code,
  input  logic                queue_full,
  output logic                in_ready,
  output cpf_pkg::front_out_t front_out
);
  import cpf_pkg::*;

  logic [7:0]  last_data_type;
  logic [7:0]  header;
  frame_desc_t desc;
  logic        keep_dtype;

  assign in_ready = !queue_full;
  assign header   = HDR_BASE | {4'h0, flight_mode};

  // classify the request
  always_comb begin
    desc.header = header;
    keep_dtype  = 1'b1;
    unique case (kind)
      KIND_NORMAL: begin
        desc.dtype = 8'h00;
        desc.axis0 = roll;
        desc.axis1 = pitch;
        desc.axis2 = yaw;
        desc.axis3 = lift;
      end
      KIND_LOWER: begin
        desc.dtype = {1'b0, tuning_code};
        desc.axis0 = 8'h00;
        desc.axis1 = 8'h00;
        desc.axis2 = 8'h00;
        desc.axis3 = 8'h00;
      end
      KIND_RAISE: begin
        desc.dtype = {1'b0, tuning_code};
        desc.axis0 = RAISE_VALUE;
        desc.axis1 = RAISE_VALUE;
        desc.axis2 = RAISE_VALUE;
        desc.axis3 = RAISE_VALUE;
      end
      KIND_PANIC: begin
        desc.dtype = last_data_type;
        desc.axis0 = header;
        desc.axis1 = header;
        desc.axis2 = header;
        desc.axis3 = header;
        keep_dtype = 1'b0;
      end
      default: begin
        desc.dtype = 8'h00;
        desc.axis0 = 8'h00;
        desc.axis1 = 8'h00;
        desc.axis2 = 8'h00;
        desc.axis3 = 8'h00;
      end
    endcase
  end

  assign front_out.push = in_valid && in_ready;
  assign front_out.desc = desc;

  // remember the data type of the latest non-panic frame
  always_ff @(posedge clk) begin
    if (rst) begin
      last_data_type <= 8'h00;
    end else if (front_out.push && keep_dtype) begin
      last_data_type <= desc.dtype;
    end
  end

endmodule

@@ rtl/core/cpf_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_fifo
// Short queue of classified frames between the front and the back end.
// ----------------------------------------------------------------------------
module cpf_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  cpf_pkg::front_out_t front_out,
  input  logic                pop,
  output logic                full,
  output cpf_pkg::queue_out_t queue_out
);
  import cpf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_desc_t      entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full            = (count == CNT_W'(DEPTH));
  assign queue_out.valid = (count != '0);
  assign queue_out.desc  = entries[rd_ptr];
  assign do_push         = front_out.push && !full;
  assign do_pop          = pop && queue_out.valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= front_out.desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/cpf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_back
// Sends each queued frame one byte per word and folds in the crc on the way.
// ----------------------------------------------------------------------------
module cpf_back (
  input  logic                clk,
  input  logic                rst,
  input  cpf_pkg::queue_out_t queue_out,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          frame_byte,
  output logic                last
);
  import cpf_pkg::*;

  frame_desc_t      desc;
  logic             active;
  logic [IDX_W-1:0] idx;
  logic [15:0]      crc;
  logic             out_acc;
  logic             load;

  assign out_valid = active;
  assign out_acc   = active && out_ready;
  assign last      = (idx == IDX_CRC_HI);
  assign load      = queue_out.valid && (!active || (out_acc && last));
  assign pop       = load;

  // byte select for the current position
  always_comb begin
    case (idx)
      IDX_HEADER: frame_byte = desc.header;
      IDX_DTYPE:  frame_byte = desc.dtype;
      IDX_AXIS0:  frame_byte = desc.axis0;
      IDX_AXIS1:  frame_byte = desc.axis1;
      IDX_AXIS2:  frame_byte = desc.axis2;
      IDX_AXIS3:  frame_byte = desc.axis3;
      IDX_CRC_LO: frame_byte = crc[7:0];
      IDX_CRC_HI: frame_byte = crc[15:8];
      default:    frame_byte = 8'h00;
    endcase
  end

  // frame sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= IDX_HEADER;
    end else if (load) begin
      active <= 1'b1;
      idx    <= IDX_HEADER;
    end else if (out_acc) begin
      if (last) begin
        active <= 1'b0;
      end
      idx <= idx + 1'b1;
    end
  end

  // frame payload and running crc over the first six bytes
  always_ff @(posedge clk) begin
    if (load) begin
      desc <= queue_out.desc;
      crc  <= CRC_INIT;
    end else if (out_acc && (idx < IDX_CRC_LO)) begin
      crc <= crc_byte(crc, frame_byte);
    end
  end

endmodule

@@ rtl/core/cpf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpf_checker
// Port-level checks on the framer output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpf_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  logic [2:0] byte_cnt;

  // position of the next output word inside its frame
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt <= 3'd0;
    end else if (m_tvalid && m_tready) begin
      byte_cnt <= byte_cnt + 3'd1;
    end
  end

  `CPF_ASSERT_ALWAYS(a_idle_after_reset, clk, rst |=> !m_tvalid, "output valid right after reset")

  `CPF_ASSERT(a_hold_on_stall, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output word changed")

  `CPF_ASSERT(a_last_on_eighth, clk, rst, m_tvalid |-> (m_tlast == (byte_cnt == 3'd7)), "tlast not on the eighth byte")

  `CPF_ASSERT(a_header_first, clk, rst, m_tvalid && (byte_cnt == 3'd0) |-> (m_tdata[7:4] == 4'hD), "first frame byte is not a header")

endmodule

bind control_packet_framer_crc16 cpf_checker u_cpf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ tb/sv/control_packet_framer_crc16_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_packet_framer_crc16_tb
// Sends framing requests on the request stream and compares every byte of
// the returned 8-byte frames, crc trailer and tlast included, against an
// independent frame builder. A directed set covers each request kind, the
// axis and mode extremes and panic with its kept data type. Random requests
// then run under changing source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module control_packet_framer_crc16_tb;
  import cpf_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 11;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int REPORT_LIMIT = 10;

  // keeps the bytes still owed by the block, in send order
  class frame_scoreboard;
    logic [8:0] frame_bytes_due[$];  // {is_last, frame byte}
    logic [7:0] kept_dtype;
    int         failures;

    function new();
      kept_dtype = 8'h00;
      failures   = 0;
    endfunction

    // crc-16 ccitt, msb first, one bit at a time
    function automatic logic [15:0] ccitt_crc(logic [7:0] frame_head[6]);
      logic [15:0] crc;
      crc = 16'hFFFF;
      foreach (frame_head[i]) begin
        crc = crc ^ {frame_head[i], 8'h00};
        for (int b = 0; b < 8; b++) begin
          if (crc[15]) begin
            crc = {crc[14:0], 1'b0} ^ 16'h1021;
          end else begin
            crc = {crc[14:0], 1'b0};
          end
        end
      end
      return crc;
    endfunction

    // build the frame for one accepted request and queue its bytes
    function void note_request(logic [1:0] kind, logic [3:0] mode,
                               logic [7:0] roll, logic [7:0] pitch,
                               logic [7:0] yaw, logic [7:0] lift,
                               logic [6:0] code);
      logic [7:0]  frame_head[6];
      logic [7:0]  header;
      logic [15:0] crc;
      header = 8'hD0 | {4'h0, mode};
      frame_head[0] = header;
      case (kind)
        KIND_NORMAL: begin
          frame_head[1] = 8'h00;
          frame_head[2] = roll;
          frame_head[3] = pitch;
          frame_head[4] = yaw;
          frame_head[5] = lift;
          kept_dtype = 8'h00;
        end
        KIND_LOWER: begin
          frame_head[1] = {1'b0, code};
          for (int i = 2; i < 6; i++) frame_head[i] = 8'h00;
          kept_dtype = {1'b0, code};
        end
        KIND_RAISE: begin
          frame_head[1] = {1'b0, code};
          for (int i = 2; i < 6; i++) frame_head[i] = 8'd64;
          kept_dtype = {1'b0, code};
        end
        default: begin
          // panic repeats the header on every axis and keeps the data type
          frame_head[1] = kept_dtype;
          for (int i = 2; i < 6; i++) frame_head[i] = header;
        end
      endcase
      crc = ccitt_crc(frame_head);
      foreach (frame_head[i]) frame_bytes_due.push_back({1'b0, frame_head[i]});
      frame_bytes_due.push_back({1'b0, crc[7:0]});
      frame_bytes_due.push_back({1'b1, crc[15:8]});
    endfunction

    // compare one output word with the oldest byte due
    function void check_byte(logic [7:0] data, logic is_last);
      logic [8:0] due;
      if (frame_bytes_due.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected word: data %02h last %0b", data, is_last);
        return;
      end
      due = frame_bytes_due.pop_front();
      if (due[7:0] !== data || due[8] !== is_last) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("word mismatch: expected data %02h last %0b, got data %02h last %0b",
                   due[7:0], due[8], data, is_last);
      end
    endfunction

    function int pending();
      return frame_bytes_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  frame_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  control_packet_framer_crc16 uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  // sink back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // output check and stall watchdog
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast);
    if (rst || (m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("control_packet_framer_crc16 test failed");
      $finish;
    end
  end

  // present one request word and hold it until taken
  task automatic send_request(logic [1:0] kind, logic [3:0] mode,
                              logic [7:0] roll, logic [7:0] pitch,
                              logic [7:0] yaw, logic [7:0] lift,
                              logic [6:0] code);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'b00000, code, lift, yaw, pitch, roll, mode};
    do @(posedge clk); while (!s_tready);
    sb.note_request(kind, mode, roll, pitch, yaw, lift, code);
  endtask

  task automatic send_random_request();
    send_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 7'($urandom_range(0, 127)));
  endtask

  initial begin
    int send_pcts[4];
    int recv_pcts[4];
    send_pcts = '{0, 82, 0, 36};
    recv_pcts = '{0, 0, 82, 36};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: panic straight out of reset uses the cleared data type
    send_request(KIND_PANIC,  4'h0, 8'h00, 8'h00, 8'h00, 8'h00, 7'd0);
    send_request(KIND_NORMAL, 4'h0, 8'h00, 8'h00, 8'h00, 8'h00, 7'd0);
    send_request(KIND_NORMAL, 4'hF, 8'h80, 8'h7F, 8'hFF, 8'h01, 7'd127);
    send_request(KIND_NORMAL, 4'h5, 8'h7F, 8'h80, 8'h01, 8'hFF, 7'd0);
    send_request(KIND_NORMAL, 4'hA, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd85);
    // panic after a normal frame keeps data type zero
    send_request(KIND_PANIC,  4'hF, 8'h12, 8'h34, 8'h56, 8'h78, 7'd99);
    send_request(KIND_LOWER,  4'h3, 8'h11, 8'h22, 8'h33, 8'h44, 7'd10);
    send_request(KIND_PANIC,  4'h3, 8'h00, 8'h00, 8'h00, 8'h00, 7'd0);
    send_request(KIND_RAISE,  4'hC, 8'hAA, 8'h55, 8'hAA, 8'h55, 7'd20);
    send_request(KIND_PANIC,  4'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd127);
    // panic twice in a row still repeats the kept type
    send_request(KIND_PANIC,  4'h9, 8'h00, 8'h00, 8'h00, 8'h00, 7'd0);
    send_request(KIND_LOWER,  4'hF, 8'h80, 8'h80, 8'h80, 8'h80, 7'd127);
    send_request(KIND_PANIC,  4'h7, 8'h00, 8'h00, 8'h00, 8'h00, 7'd0);
    send_request(KIND_RAISE,  4'h0, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 7'd0);
    send_request(KIND_PANIC,  4'hF, 8'h00, 8'h00, 8'h00, 8'h00, 7'd0);
    send_request(KIND_RAISE,  4'h6, 8'h00, 8'h00, 8'h00, 8'h00, 7'd30);
    send_request(KIND_NORMAL, 4'h1, 8'h01, 8'h02, 8'h04, 8'h08, 7'd64);
    send_request(KIND_PANIC,  4'h2, 8'h00, 8'h00, 8'h00, 8'h00, 7'd0);

    // random requests under each idling mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      repeat (ITEMS_PER_PHASE) send_random_request();
    end
    s_tvalid <= 1'b0;
    recv_stall_pct = 0;

    // drain, then allow a margin for any stray words
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0) begin
      $display("control_packet_framer_crc16 test passed");
    end else begin
      $display("control_packet_framer_crc16 test failed");
    end
    $finish;
  end

endmodule
